FILE: hw/rtl/rfe_pkg.sv
// Shared types and constants of the image rotate and flip engine.
package rfe_pkg;

  localparam int PIX_W      = 24;
  localparam int CFG_DIM_W  = 8;
  localparam int CFG_MODE_W = 3;
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  localparam logic [CFG_DIM_W-1:0] DIM_RESET = 8'd128;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef enum logic [CFG_MODE_W-1:0] {
    MODE_ROT_LEFT  = 3'd0,
    MODE_ROT_RIGHT = 3'd1,
    MODE_FLIP_V    = 3'd2,
    MODE_FLIP_H    = 3'd3,
    MODE_NONE      = 3'd4
  } rfe_mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_MUL,
    ST_RD,
    ST_OUT
  } rfe_state_e;

  typedef struct packed {
    logic             command;
    logic [PIX_W-1:0] pixel_in;
  } rfe_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             row_end;
    logic             last_pixel;
    logic             not_ready;
  } rfe_out_t;

  typedef struct packed {
    logic take;
    logic calc;
    logic mul;
    logic rd;
    logic wb;
  } rfe_cmd_t;

  typedef struct packed {
    logic is_read;
    logic frame_ready;
    logic out_free;
  } rfe_sts_t;

endpackage

FILE: hw/rtl/rfe_stream_if.sv
// Valid/ready stream channel carrying one payload struct.
interface rfe_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/rfe_ram.sv
// Simple dual-port RAM, one write port and one registered read port.
module rfe_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

FILE: hw/rtl/rfe_ctrl.sv
// Sequencing state machine of the image rotate and flip engine.
module rfe_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  rfe_pkg::rfe_sts_t sts_i,
  output rfe_pkg::rfe_cmd_t cmd_o
);
  import rfe_pkg::*;

  rfe_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_CALC;
      end
      ST_CALC: begin
        if (!sts_i.is_read) state_d = ST_IDLE;
        else if (!sts_i.frame_ready) state_d = ST_OUT;
        else state_d = ST_MUL;
      end
      ST_MUL:  state_d = ST_RD;
      ST_RD:   state_d = ST_OUT;
      ST_OUT: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.take = in_valid_i;
      end
      ST_CALC: cmd_o.calc = 1'b1;
      ST_MUL:  cmd_o.mul  = 1'b1;
      ST_RD:   cmd_o.rd   = 1'b1;
      ST_OUT:  cmd_o.wb   = sts_i.out_free;
      default: cmd_o = '0;
    endcase
  end
endmodule

FILE: hw/rtl/rfe_dp.sv
// Datapath: frame counters, address generation, frame store and output register.
module rfe_dp #(
  parameter int MAX_DIM    = 128
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [rfe_pkg::CFG_MODE_W-1:0]     mode_i,
  input  logic [rfe_pkg::CFG_DIM_W-1:0]      width_i,
  input  logic [rfe_pkg::CFG_DIM_W-1:0]      height_i,
  input  rfe_pkg::rfe_in_t                   in_data_i,
  input  rfe_pkg::rfe_cmd_t                  cmd_i,
  output rfe_pkg::rfe_sts_t                  sts_o,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output rfe_pkg::rfe_out_t                  out_data_o
);
  import rfe_pkg::*;

  localparam int DIM_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int SIZE_W = $clog2(MAX_DIM + 1);
  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  function automatic logic [SIZE_W-1:0] eff_dim(input logic [CFG_DIM_W-1:0] v);
    logic [SIZE_W-1:0] res;
    if (v == '0) res = SIZE_W'(1);
    else if (int'(v) > MAX_DIM) res = SIZE_W'(MAX_DIM);
    else res = SIZE_W'(v);
    return res;
  endfunction

  logic                  cmd_q;
  logic [PIX_W-1:0]      pix_q;
  logic [CNT_W-1:0]      load_cnt_q, load_cnt_d;
  logic [DIM_W-1:0]      row_q, row_d, col_q, col_d;
  logic                  full_q, full_d;
  logic                  out_valid_q, out_valid_d;
  rfe_out_t              out_data_q;
  logic [DIM_W-1:0]      sr_q, sc_q, r_q, c_q;
  logic                  re_q, last_q, nr_q;
  logic [ADDR_W-1:0]     idx_q;

  logic [SIZE_W-1:0]     w, h, ow, oh;
  logic [CNT_W-1:0]      total, cnt_inc;
  logic                  eff_full, rot, row_end, last;
  logic [DIM_W-1:0]      r, c, sr, sc;
  logic                  mem_we;
  logic [PIX_W-1:0]      mem_rdata;

  assign w        = eff_dim(width_i);
  assign h        = eff_dim(height_i);
  assign total    = CNT_W'(w) * CNT_W'(h);
  assign cnt_inc  = load_cnt_q + CNT_W'(1);
  assign eff_full = full_q | (load_cnt_q >= total);
  assign rot      = (mode_i == MODE_ROT_LEFT) || (mode_i == MODE_ROT_RIGHT);
  assign ow       = rot ? h : w;
  assign oh       = rot ? w : h;

  always_comb begin
    r = (SIZE_W'(row_q) < oh) ? row_q : DIM_W'(oh - SIZE_W'(1));
    c = (SIZE_W'(col_q) < ow) ? col_q : DIM_W'(ow - SIZE_W'(1));
    case (mode_i)
      MODE_ROT_LEFT: begin
        sr = c;
        sc = DIM_W'(w - SIZE_W'(1) - SIZE_W'(r));
      end
      MODE_ROT_RIGHT: begin
        sr = DIM_W'(h - SIZE_W'(1) - SIZE_W'(c));
        sc = r;
      end
      MODE_FLIP_V: begin
        sr = DIM_W'(h - SIZE_W'(1) - SIZE_W'(r));
        sc = c;
      end
      MODE_FLIP_H: begin
        sr = r;
        sc = DIM_W'(w - SIZE_W'(1) - SIZE_W'(c));
      end
      default: begin
        sr = r;
        sc = c;
      end
    endcase
    row_end = (SIZE_W'(c) == ow - SIZE_W'(1));
    last    = row_end && (SIZE_W'(r) == oh - SIZE_W'(1));
  end

  assign mem_we = cmd_i.calc && (cmd_q == CMD_LOAD) && !eff_full;

  assign sts_o.is_read     = (cmd_q == CMD_READ);
  assign sts_o.frame_ready = eff_full;
  assign sts_o.out_free    = !out_valid_q || out_ready_i;

  always_comb begin
    load_cnt_d  = load_cnt_q;
    row_d       = row_q;
    col_d       = col_q;
    full_d      = full_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (cmd_i.calc) begin
      full_d = eff_full;
      if (mem_we) begin
        load_cnt_d = cnt_inc;
        full_d     = (cnt_inc >= total);
      end
    end
    if (cmd_i.wb) begin
      out_valid_d = 1'b1;
      if (!nr_q) begin
        if (last_q) begin
          load_cnt_d = '0;
          row_d      = '0;
          col_d      = '0;
          full_d     = 1'b0;
        end else if (re_q) begin
          col_d = '0;
          row_d = r_q + DIM_W'(1);
        end else begin
          col_d = c_q + DIM_W'(1);
          row_d = r_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_cnt_q  <= '0;
      row_q       <= '0;
      col_q       <= '0;
      full_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      load_cnt_q  <= load_cnt_d;
      row_q       <= row_d;
      col_q       <= col_d;
      full_q      <= full_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      cmd_q <= in_data_i.command;
      pix_q <= in_data_i.pixel_in;
    end
    if (cmd_i.calc) begin
      nr_q   <= !eff_full;
      sr_q   <= sr;
      sc_q   <= sc;
      r_q    <= r;
      c_q    <= c;
      re_q   <= row_end;
      last_q <= last;
    end
    if (cmd_i.mul) begin
      idx_q <= ADDR_W'(ADDR_W'(sr_q) * ADDR_W'(w)) + ADDR_W'(sc_q);
    end
    if (cmd_i.wb) begin
      if (nr_q) begin
        out_data_q.pixel_out  <= '0;
        out_data_q.row_end    <= 1'b0;
        out_data_q.last_pixel <= 1'b0;
        out_data_q.not_ready  <= 1'b1;
      end else begin
        out_data_q.pixel_out  <= mem_rdata;
        out_data_q.row_end    <= re_q;
        out_data_q.last_pixel <= last_q;
        out_data_q.not_ready  <= 1'b0;
      end
    end
  end

  rfe_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_frame_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (ADDR_W'(load_cnt_q)),
    .wdata_i (pix_q),
    .re_i    (cmd_i.rd),
    .raddr_i (idx_q),
    .rdata_o (mem_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
endmodule

FILE: hw/rtl/image_rotate_flip_engine.sv
// Top level of the image rotate and flip engine with its APB register file.
//
// Usage: program mode, image_width and image_height over APB (byte addresses
// 0, 4, 8) while the engine is idle. Send transactions on in_i: command 0
// loads the next pixel of the source image in raster order, command 1 reads
// the next pixel of the transformed image in output raster order. Each read
// returns one transaction on out_o with row_end and last_pixel flags; a read
// before the frame is fully loaded returns not_ready with a zero pixel.
// Loads beyond a full frame are dropped. After the last pixel is read the
// engine starts over with a new frame.
// Sequence: one item is in flight at a time. A load passes take and count
// update; an early read also the output register; a read of the frame
// take, count update, index multiply, frame store read, output register.
// The output register holds a result while out_o stalls; the next
// transaction is accepted meanwhile and a following read waits in its
// last step until the register frees.
// Reset clears counters and flags and sets mode none, 128 by 128; the
// frame store and the data registers are not cleared.
module image_rotate_flip_engine #(
  parameter int MAX_DIM    = 128
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rfe_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [rfe_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [rfe_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready,
  rfe_stream_if.sink                        in_i,
  rfe_stream_if.source                      out_o
);
  import rfe_pkg::*;

  logic [CFG_MODE_W-1:0] mode_q;
  logic [CFG_DIM_W-1:0]  width_q, height_q;
  logic                  wr_en, in_ready, out_valid;
  logic [1:0]            reg_idx;
  rfe_cmd_t              cmd;
  rfe_sts_t              sts;
  rfe_out_t              out_data;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_NONE;
      width_q  <= DIM_RESET;
      height_q <= DIM_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        REG_MODE:   mode_q   <= pwdata[CFG_MODE_W-1:0];
        REG_WIDTH:  width_q  <= pwdata[CFG_DIM_W-1:0];
        REG_HEIGHT: height_q <= pwdata[CFG_DIM_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MODE:   prdata = APB_DATA_W'(mode_q);
      REG_WIDTH:  prdata = APB_DATA_W'(width_q);
      REG_HEIGHT: prdata = APB_DATA_W'(height_q);
      default:    prdata = '0;
    endcase
  end

  rfe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rfe_dp #(
    .MAX_DIM    (MAX_DIM)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mode_i      (mode_q),
    .width_i     (width_q),
    .height_i    (height_q),
    .in_data_i   (in_i.data),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .out_data_o  (out_data)
  );

  assign in_i.ready = in_ready;
  assign out_o.valid = out_valid;
  assign out_o.data  = out_data;

  a_not_ready_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.data.not_ready |->
      out_o.data.pixel_out == '0 && !out_o.data.row_end && !out_o.data.last_pixel)
    else $error("not_ready transaction carries pixel data or flags");

  a_last_ends_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.data.last_pixel |-> out_o.data.row_end)
    else $error("last_pixel without row_end");

  a_load_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_ready && (in_i.data.command == CMD_LOAD) |=>
      !$rose(out_o.valid))
    else $error("load transaction produced a result");
endmodule

FILE: bench/tb_top.sv
// Testbench for the image rotate and flip engine: a transform predictor and result scoreboard.
`timescale 1ns / 100ps

module tb_top;
  import rfe_pkg::*;

  localparam int DIM_MAX = 128;
  localparam int STORE_DEPTH = DIM_MAX * DIM_MAX;
  localparam int DRAIN_CYCLES = 8;
  localparam int IDLE_LIMIT = 2000;
  localparam int PHASE_ITEMS = 450;
  localparam int HOLD_CYCLES = 300;
  localparam logic [CFG_MODE_W-1:0] MODE_MAX_CODE = 3'd7;

  class xform_checker;
    logic [CFG_MODE_W-1:0] mode_reg;
    logic [CFG_DIM_W-1:0] width_reg;
    logic [CFG_DIM_W-1:0] height_reg;
    logic [PIX_W-1:0] pixels [STORE_DEPTH];
    int written_top;
    int load_count;
    int out_row;
    int out_col;
    bit frame_full;
    int frames_done;
    int items_taken;
    int errors;
    rfe_out_t expected_pixels [$];

    function new();
      mode_reg = MODE_NONE;
      width_reg = DIM_RESET;
      height_reg = DIM_RESET;
      written_top = 0;
      load_count = 0;
      out_row = 0;
      out_col = 0;
      frame_full = 0;
      frames_done = 0;
      items_taken = 0;
      errors = 0;
    endfunction

    function int dim(logic [CFG_DIM_W-1:0] v);
      if (v == 0) return 1;
      if (v > DIM_MAX) return DIM_MAX;
      return v;
    endfunction

    function bit complete();
      return frame_full || load_count >= dim(width_reg) * dim(height_reg);
    endfunction

    // Enlarging a loaded frame must not reach store entries never written.
    function bit sizes_safe(int w, int h);
      return !frame_full || dim(w) * dim(h) <= written_top;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        REG_MODE: mode_reg = val[CFG_MODE_W-1:0];
        REG_WIDTH: width_reg = val[CFG_DIM_W-1:0];
        REG_HEIGHT: height_reg = val[CFG_DIM_W-1:0];
        default: ;
      endcase
    endfunction

    function void predict_item(rfe_in_t it);
      int w, h, total, ow, oh, r, c, sr, sc;
      bit rot;
      rfe_out_t res;
      w = dim(width_reg);
      h = dim(height_reg);
      total = w * h;
      if (load_count >= total) frame_full = 1;
      if (it.command == CMD_LOAD) begin
        if (!frame_full) begin
          pixels[load_count] = it.pixel_in;
          load_count++;
          items_taken++;
          if (load_count > written_top) written_top = load_count;
          if (load_count >= total) frame_full = 1;
        end
        return;
      end
      items_taken++;
      res = '0;
      if (!frame_full) begin
        res.not_ready = 1'b1;
        expected_pixels.push_back(res);
        return;
      end
      rot = mode_reg == MODE_ROT_LEFT || mode_reg == MODE_ROT_RIGHT;
      ow = rot ? h : w;
      oh = rot ? w : h;
      r = out_row < oh ? out_row : oh - 1;
      c = out_col < ow ? out_col : ow - 1;
      case (mode_reg)
        MODE_ROT_LEFT: begin
          sr = c;
          sc = w - 1 - r;
        end
        MODE_ROT_RIGHT: begin
          sr = h - 1 - c;
          sc = r;
        end
        MODE_FLIP_V: begin
          sr = h - 1 - r;
          sc = c;
        end
        MODE_FLIP_H: begin
          sr = r;
          sc = w - 1 - c;
        end
        default: begin
          sr = r;
          sc = c;
        end
      endcase
      res.pixel_out = pixels[sr * w + sc];
      res.row_end = c == ow - 1;
      res.last_pixel = res.row_end && r == oh - 1;
      expected_pixels.push_back(res);
      if (res.last_pixel) begin
        load_count = 0;
        out_row = 0;
        out_col = 0;
        frame_full = 0;
        frames_done++;
      end else if (res.row_end) begin
        out_col = 0;
        out_row = r + 1;
      end else begin
        out_col = c + 1;
        out_row = r;
      end
    endfunction

    task report_mismatch(string msg);
      if (errors < 100) $display("ERROR at %0t: %s", $time, msg);
      errors++;
    endtask

    task check_pixel(rfe_out_t got);
      rfe_out_t want;
      if (expected_pixels.size() == 0) begin
        report_mismatch($sformatf("unexpected transaction, pixel %06h", got.pixel_out));
        return;
      end
      want = expected_pixels.pop_front();
      if (got.pixel_out !== want.pixel_out)
        report_mismatch($sformatf("pixel_out %06h, want %06h", got.pixel_out, want.pixel_out));
      if (got.row_end !== want.row_end)
        report_mismatch($sformatf("row_end %b, want %b", got.row_end, want.row_end));
      if (got.last_pixel !== want.last_pixel)
        report_mismatch($sformatf("last_pixel %b, want %b", got.last_pixel, want.last_pixel));
      if (got.not_ready !== want.not_ready)
        report_mismatch($sformatf("not_ready %b, want %b", got.not_ready, want.not_ready));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  rfe_stream_if #(.T(rfe_in_t)) in_if ();
  rfe_stream_if #(.T(rfe_out_t)) out_if ();

  xform_checker sb;
  int tx_idle;
  int rx_idle;
  int hold_left;
  int quiet_cycles;

  image_rotate_flip_engine dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_i    (in_if),
    .out_o   (out_if)
  );

  always #6 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_if.ready <= 1'b0;
      hold_left--;
    end else begin
      out_if.ready <= $urandom_range(0, 99) >= rx_idle;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) sb.check_pixel(out_if.data);
    if (!rst_ni || psel || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_item(input logic cmd, input logic [PIX_W-1:0] pix);
    rfe_in_t it;
    it.command = cmd;
    it.pixel_in = pix;
    @(negedge clk_i);
    while ($urandom_range(0, 99) < tx_idle) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data <= it;
    do @(posedge clk_i); while (!in_if.ready);
    sb.predict_item(it);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (sb.expected_pixels.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apb_check(input logic [1:0] idx, input logic [31:0] want);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== want)
      sb.report_mismatch($sformatf("register %0d reads %08h, want %08h", idx, prdata, want));
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic cfg_write(input logic [1:0] idx, input int field);
    logic [31:0] data;
    logic [31:0] want;
    data = $urandom();
    if (idx == REG_MODE) begin
      data[CFG_MODE_W-1:0] = field[CFG_MODE_W-1:0];
      want = {29'b0, data[CFG_MODE_W-1:0]};
    end else begin
      data[CFG_DIM_W-1:0] = field[CFG_DIM_W-1:0];
      want = {24'b0, data[CFG_DIM_W-1:0]};
    end
    apb_write(idx, data);
    sb.write_reg(idx, data);
    apb_check(idx, want);
  endtask

  task automatic set_frame(input logic [CFG_MODE_W-1:0] m, input int w, input int h);
    cfg_write(REG_MODE, m);
    cfg_write(REG_WIDTH, w);
    cfg_write(REG_HEIGHT, h);
  endtask

  task automatic run_frame(input logic [CFG_MODE_W-1:0] m, input int w, input int h,
                           input bit long_hold);
    int n;
    int reconfig_at;
    int start;
    int nd;
    logic cmd;
    drain();
    set_frame(m, w, h);
    start = sb.frames_done;
    n = 0;
    reconfig_at = ($urandom_range(0, 9) == 0) ?
                  $urandom_range(0, 2 * sb.dim(w) * sb.dim(h)) : -1;
    while (sb.frames_done == start) begin
      if (n == reconfig_at) begin
        drain();
        nd = $urandom_range(1, 8);
        case ($urandom_range(0, 2))
          0: cfg_write(REG_MODE, $urandom_range(int'(MODE_ROT_LEFT), int'(MODE_MAX_CODE)));
          1: if (sb.sizes_safe(nd, sb.height_reg)) cfg_write(REG_WIDTH, nd);
          default: if (sb.sizes_safe(sb.width_reg, nd)) cfg_write(REG_HEIGHT, nd);
        endcase
      end
      if (!sb.complete())
        cmd = ($urandom_range(0, 99) < 90) ? CMD_LOAD : CMD_READ;
      else
        cmd = ($urandom_range(0, 99) < 94) ? CMD_READ : CMD_LOAD;
      send_item(cmd, PIX_W'($urandom()));
      if (long_hold && cmd == CMD_READ && sb.frame_full) begin
        hold_left = HOLD_CYCLES;
        long_hold = 0;
      end
      n++;
    end
  endtask

  task automatic random_frame();
    logic [CFG_MODE_W-1:0] m;
    int w;
    int h;
    int pick;
    if ($urandom_range(0, 9) != 0)
      m = CFG_MODE_W'($urandom_range(int'(MODE_ROT_LEFT), int'(MODE_NONE)));
    else
      m = CFG_MODE_W'($urandom_range(int'(MODE_NONE) + 1, int'(MODE_MAX_CODE)));
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      w = $urandom_range(1, 6);
      h = $urandom_range(1, 6);
    end else if (pick < 92) begin
      w = $urandom_range(1, 16);
      h = $urandom_range(1, 16);
    end else if (pick < 96) begin
      w = $urandom_range(0, 1) ? 0 : $urandom_range(DIM_MAX + 1, 255);
      h = $urandom_range(1, 3);
      if ($urandom_range(0, 1)) begin
        pick = w;
        w = h;
        h = pick;
      end
    end else begin
      w = $urandom_range(1, 24);
      h = $urandom_range(1, 24);
    end
    run_frame(m, w, h, 0);
  endtask

  initial begin
    logic [PIX_W-1:0] corner_pix [6];
    int target;
    corner_pix = '{24'h000000, 24'hFFFFFF, 24'hAAAAAA, 24'h555555, 24'h0F0F0F, 24'hF0F0F0};
    sb = new();
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
    tx_idle = 0;
    rx_idle = 0;
    hold_left = 0;
    quiet_cycles = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    apb_check(REG_MODE, {29'b0, MODE_NONE});
    apb_check(REG_WIDTH, {24'b0, DIM_RESET});
    apb_check(REG_HEIGHT, {24'b0, DIM_RESET});

    send_item(CMD_READ, 24'hFFFFFF);
    drain();
    set_frame(MODE_ROT_LEFT, 3, 2);
    for (int i = 0; i < 6; i++) send_item(CMD_LOAD, corner_pix[i]);
    send_item(CMD_LOAD, 24'h123456);
    repeat (6) send_item(CMD_READ, '0);
    drain();
    set_frame(MODE_MAX_CODE, 0, 1);
    send_item(CMD_LOAD, 24'hFFFFFF);
    send_item(CMD_READ, 24'hFFFFFF);
    drain();
    set_frame(MODE_FLIP_H, 2, 1);
    send_item(CMD_LOAD, 24'h00FF00);
    send_item(CMD_LOAD, 24'hFF00FF);
    send_item(CMD_READ, '0);
    drain();
    cfg_write(REG_MODE, MODE_FLIP_V);
    send_item(CMD_READ, '0);

    tx_idle = 31;
    rx_idle = 54;
    target = sb.items_taken + PHASE_ITEMS;
    while (sb.items_taken < target) random_frame();

    tx_idle = 54;
    rx_idle = 31;
    target = sb.items_taken + PHASE_ITEMS;
    run_frame(MODE_ROT_RIGHT, 4, 4, 1);
    while (sb.items_taken < target) random_frame();

    tx_idle = 0;
    rx_idle = 0;
    target = sb.items_taken + PHASE_ITEMS;
    run_frame(CFG_MODE_W'($urandom_range(int'(MODE_ROT_LEFT), int'(MODE_NONE))), 255, 1, 0);
    while (sb.items_taken < target) random_frame();

    drain();
    if (sb.errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
